FILE: rtl/core/i2ctb_pkg.sv
// shared types and constants of the i2c target bit engine
package i2ctb_pkg;

    localparam int DEF_BUF_DEPTH = 32;
    localparam int ADDR_W        = 7;
    localparam int STAT_W        = 6;
    localparam int BIT_CNT_W     = 4;
    localparam int BYTE_W        = 8;

    localparam logic [BYTE_W-1:0]    BYTE_ALL_ONES = 8'hFF;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [2:0]           MSB_INDEX     = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_RXDATA = 3'd2,
        PH_ACKOUT = 3'd3,
        PH_TXDATA = 3'd4,
        PH_TXACK  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        OP_PIN_SAMPLE = 2'd0,
        OP_TX_PUSH    = 2'd1,
        OP_RX_POP     = 2'd2
    } op_t;

endpackage

FILE: rtl/core/i2ctb_ram.sv
// generic single-clock ram, one write port and one registered read port
module i2ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/i2ctb_store_port.sv
// byte store with continuous read of the next take pointer and write forwarding
module i2ctb_store_port #(
    parameter int DEPTH = i2ctb_pkg::DEF_BUF_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [i2ctb_pkg::BYTE_W-1:0]  wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [i2ctb_pkg::BYTE_W-1:0]  rd_data
);

    logic [i2ctb_pkg::BYTE_W-1:0] ram_rd_data;
    logic                         fwd_reg;
    logic                         fwd_next;
    logic [i2ctb_pkg::BYTE_W-1:0] fwd_data_reg;

    i2ctb_ram #(
        .WIDTH (i2ctb_pkg::BYTE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ram reads old data on a same-address write, so take the new byte instead
    assign fwd_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= fwd_next;
        end
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_reg ? fwd_data_reg : ram_rd_data;

endmodule

FILE: rtl/core/i2c_target_bit_engine.sv
// i2c target bit engine: bus phase logic, queue pointers and result register
// result: each accepted transaction is registered into the result register
// throughput: one item per cycle while m_ready is high; each store reads the entry at the
//   next take pointer every cycle, so the head byte is ready when the following item needs it
// reset: synchronous active-low aresetn clears phase, counters, pointers and the
//   result valid flag, not its payload; store contents are not cleared nor read unwritten
module i2c_target_bit_engine #(
    parameter int BUF_DEPTH = i2ctb_pkg::DEF_BUF_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [i2ctb_pkg::ADDR_W-1:0]  cfg_own_address,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic                          s_scl_level,
    input  logic                          s_sda_level,
    input  logic [i2ctb_pkg::BYTE_W-1:0]  s_tx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_sda_pull_low,
    output logic [i2ctb_pkg::BYTE_W-1:0]  m_rx_byte,
    output logic                          m_rx_valid,
    output logic [i2ctb_pkg::STAT_W-1:0]  m_rx_waiting,
    output logic                          m_tx_accepted,
    output logic                          m_receive_done,
    output logic [i2ctb_pkg::STAT_W-1:0]  m_receive_count,
    output logic                          m_bus_busy
);

    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // configuration
    logic [i2ctb_pkg::ADDR_W-1:0] own_address_reg;

    // bus state
    i2ctb_pkg::phase_t                phase_reg, phase_next;
    logic [i2ctb_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [i2ctb_pkg::BYTE_W-1:0]     shift_reg, shift_next;
    logic                             master_reads_reg, master_reads_next;
    logic                             last_scl_reg, last_scl_next;
    logic                             last_sda_reg, last_sda_next;
    logic                             drive_low_reg, drive_low_next;

    // queue pointers
    logic [CW-1:0] rx_fill_reg, rx_fill_next;
    logic [CW-1:0] rx_take_reg, rx_take_next;
    logic [CW-1:0] tx_fill_reg, tx_fill_next;
    logic [CW-1:0] tx_take_reg, tx_take_next;

    // store ports
    logic                         rx_wr_en, tx_wr_en;
    logic [AW-1:0]                rx_wr_addr, tx_wr_addr;
    logic [i2ctb_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;

    // result register
    logic                         out_valid_reg;
    logic                         out_sda_reg;
    logic [i2ctb_pkg::BYTE_W-1:0] out_rx_byte_reg, rx_byte_next;
    logic                         out_rx_valid_reg, rx_valid_next;
    logic [i2ctb_pkg::STAT_W-1:0] out_waiting_reg, waiting_next;
    logic                         out_tx_acc_reg, tx_acc_next;
    logic                         out_done_reg, done_next;
    logic [i2ctb_pkg::STAT_W-1:0] out_count_reg, count_next;
    logic                         out_busy_reg, busy_next;

    logic accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_comb begin
        logic                        held_high;
        logic [CW-1:0]               tx_fill_w;
        logic [2:0]                  bit_idx;
        logic                        do_drive;

        phase_next        = phase_reg;
        bit_cnt_next      = bit_cnt_reg;
        shift_next        = shift_reg;
        master_reads_next = master_reads_reg;
        last_scl_next     = last_scl_reg;
        last_sda_next     = last_sda_reg;
        drive_low_next    = drive_low_reg;
        rx_fill_next      = rx_fill_reg;
        rx_take_next      = rx_take_reg;
        tx_fill_next      = tx_fill_reg;
        tx_take_next      = tx_take_reg;
        rx_wr_en          = 1'b0;
        tx_wr_en          = 1'b0;
        rx_wr_addr        = rx_fill_reg[AW-1:0];
        tx_fill_w         = tx_fill_reg;
        rx_byte_next      = '0;
        rx_valid_next     = 1'b0;
        tx_acc_next       = 1'b0;
        done_next         = 1'b0;
        count_next        = '0;
        held_high         = last_scl_reg && s_scl_level;
        do_drive          = 1'b0;

        if (accept) begin
            case (s_op)
                i2ctb_pkg::OP_PIN_SAMPLE: begin
                    if (held_high && last_sda_reg && !s_sda_level) begin
                        // start condition, transmit queue survives
                        phase_next     = i2ctb_pkg::PH_ADDR;
                        bit_cnt_next   = '0;
                        shift_next     = '0;
                        drive_low_next = 1'b0;
                        rx_fill_next   = '0;
                        rx_take_next   = '0;
                    end else if (held_high && !last_sda_reg && s_sda_level) begin
                        if (!master_reads_reg && (phase_reg inside
                                {[i2ctb_pkg::PH_RXDATA:i2ctb_pkg::PH_TXACK]})) begin
                            done_next  = 1'b1;
                            count_next = i2ctb_pkg::STAT_W'(rx_fill_reg);
                        end
                        phase_next     = i2ctb_pkg::PH_IDLE;
                        drive_low_next = 1'b0;
                    end else if (!last_scl_reg && s_scl_level) begin
                        case (phase_reg)
                            i2ctb_pkg::PH_ADDR, i2ctb_pkg::PH_RXDATA: begin
                                if (bit_cnt_reg < i2ctb_pkg::BITS_PER_BYTE) begin
                                    shift_next   = {shift_reg[i2ctb_pkg::BYTE_W-2:0],
                                                    s_sda_level};
                                    bit_cnt_next = bit_cnt_reg + 1'b1;
                                end
                            end
                            i2ctb_pkg::PH_TXDATA: begin
                                if (bit_cnt_reg < i2ctb_pkg::BITS_PER_BYTE) begin
                                    bit_cnt_next = bit_cnt_reg + 1'b1;
                                end
                            end
                            i2ctb_pkg::PH_TXACK: begin
                                if (s_sda_level) begin
                                    phase_next = i2ctb_pkg::PH_IDLE;
                                end else begin
                                    phase_next   = i2ctb_pkg::PH_TXDATA;
                                    bit_cnt_next = '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (last_scl_reg && !s_scl_level) begin
                        case (phase_reg)
                            i2ctb_pkg::PH_ADDR: begin
                                if (bit_cnt_reg >= i2ctb_pkg::BITS_PER_BYTE) begin
                                    if (shift_reg[i2ctb_pkg::BYTE_W-1:1] == own_address_reg) begin
                                        master_reads_next = shift_reg[0];
                                        phase_next        = i2ctb_pkg::PH_ACKOUT;
                                        drive_low_next    = 1'b1;
                                    end else begin
                                        phase_next     = i2ctb_pkg::PH_IDLE;
                                        drive_low_next = 1'b0;
                                    end
                                end
                            end
                            i2ctb_pkg::PH_RXDATA: begin
                                if (bit_cnt_reg >= i2ctb_pkg::BITS_PER_BYTE) begin
                                    // a full queue drops the byte but still acks it
                                    if (rx_fill_reg < DEPTH_C) begin
                                        rx_wr_en     = 1'b1;
                                        rx_fill_next = rx_fill_reg + ONE_C;
                                    end
                                    phase_next     = i2ctb_pkg::PH_ACKOUT;
                                    drive_low_next = 1'b1;
                                end
                            end
                            i2ctb_pkg::PH_ACKOUT: begin
                                drive_low_next = 1'b0;
                                bit_cnt_next   = '0;
                                if (master_reads_reg) begin
                                    phase_next = i2ctb_pkg::PH_TXDATA;
                                    do_drive   = 1'b1;
                                end else begin
                                    phase_next = i2ctb_pkg::PH_RXDATA;
                                    shift_next = '0;
                                end
                            end
                            i2ctb_pkg::PH_TXDATA: begin
                                if (bit_cnt_reg >= i2ctb_pkg::BITS_PER_BYTE) begin
                                    drive_low_next = 1'b0;
                                    phase_next     = i2ctb_pkg::PH_TXACK;
                                end else begin
                                    do_drive = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    last_scl_next = s_scl_level;
                    last_sda_next = s_sda_level;
                end
                i2ctb_pkg::OP_TX_PUSH: begin
                    if (tx_take_reg >= tx_fill_reg) begin
                        tx_take_next = '0;
                        tx_fill_w    = '0;
                    end
                    tx_fill_next = tx_fill_w;
                    if (tx_fill_w < DEPTH_C) begin
                        tx_wr_en     = 1'b1;
                        tx_fill_next = tx_fill_w + ONE_C;
                        tx_acc_next  = 1'b1;
                    end
                end
                i2ctb_pkg::OP_RX_POP: begin
                    if (rx_take_reg < rx_fill_reg && rx_take_reg < DEPTH_C) begin
                        rx_byte_next  = rx_rd_data;
                        rx_valid_next = 1'b1;
                        rx_take_next  = rx_take_reg + ONE_C;
                    end
                end
                default: begin
                end
            endcase
        end

        // next transmit bit; a byte boundary first loads the queue head or all ones
        if (do_drive) begin
            if (bit_cnt_next == '0) begin
                if (tx_take_reg < tx_fill_reg && tx_take_reg < DEPTH_C) begin
                    shift_next   = tx_rd_data;
                    tx_take_next = tx_take_reg + ONE_C;
                end else begin
                    shift_next = i2ctb_pkg::BYTE_ALL_ONES;
                end
            end
            bit_idx        = i2ctb_pkg::MSB_INDEX - bit_cnt_next[2:0];
            drive_low_next = !shift_next[bit_idx];
        end else begin
            bit_idx = '0;
        end

        tx_wr_addr   = tx_fill_w[AW-1:0];
        waiting_next = (rx_fill_next >= rx_take_next) ?
                       i2ctb_pkg::STAT_W'(rx_fill_next - rx_take_next) : '0;
        busy_next    = (phase_next inside {[i2ctb_pkg::PH_RXDATA:i2ctb_pkg::PH_TXACK]});
    end

    i2ctb_store_port #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_rx_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (shift_reg),
        .rd_addr (rx_take_next[AW-1:0]),
        .rd_data (rx_rd_data)
    );

    i2ctb_store_port #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_tx_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (s_tx_byte),
        .rd_addr (tx_take_next[AW-1:0]),
        .rd_data (tx_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg  <= '0;
            phase_reg        <= i2ctb_pkg::PH_IDLE;
            bit_cnt_reg      <= '0;
            shift_reg        <= '0;
            master_reads_reg <= 1'b0;
            last_scl_reg     <= 1'b1;
            last_sda_reg     <= 1'b1;
            drive_low_reg    <= 1'b0;
            rx_fill_reg      <= '0;
            rx_take_reg      <= '0;
            tx_fill_reg      <= '0;
            tx_take_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                own_address_reg <= cfg_own_address;
            end
            phase_reg        <= phase_next;
            bit_cnt_reg      <= bit_cnt_next;
            shift_reg        <= shift_next;
            master_reads_reg <= master_reads_next;
            last_scl_reg     <= last_scl_next;
            last_sda_reg     <= last_sda_next;
            drive_low_reg    <= drive_low_next;
            rx_fill_reg      <= rx_fill_next;
            rx_take_reg      <= rx_take_next;
            tx_fill_reg      <= tx_fill_next;
            tx_take_reg      <= tx_take_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_sda_reg      <= drive_low_next;
            out_rx_byte_reg  <= rx_byte_next;
            out_rx_valid_reg <= rx_valid_next;
            out_waiting_reg  <= waiting_next;
            out_tx_acc_reg   <= tx_acc_next;
            out_done_reg     <= done_next;
            out_count_reg    <= count_next;
            out_busy_reg     <= busy_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_sda_pull_low  = out_sda_reg;
    assign m_rx_byte       = out_rx_byte_reg;
    assign m_rx_valid      = out_rx_valid_reg;
    assign m_rx_waiting    = out_waiting_reg;
    assign m_tx_accepted   = out_tx_acc_reg;
    assign m_receive_done  = out_done_reg;
    assign m_receive_count = out_count_reg;
    assign m_bus_busy      = out_busy_reg;

endmodule

FILE: rtl/core/i2ctb_checker.sv
// port-level checks of the i2c target bit engine and their bind
module i2ctb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_sda_pull_low,
    input logic [i2ctb_pkg::BYTE_W-1:0]  m_rx_byte,
    input logic                          m_rx_valid,
    input logic                          m_tx_accepted,
    input logic                          m_receive_done,
    input logic [i2ctb_pkg::STAT_W-1:0]  m_receive_count,
    input logic                          m_bus_busy
);

    // a stalled result transaction holds its rx byte and receive count
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rx_byte) && $stable(m_receive_count))
        else $error("result changed while stalled");

    // an empty pop reports a zero byte
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rx_valid |-> m_rx_byte == '0)
        else $error("rx byte nonzero without rx valid");

    // count is only reported with receive done
    a_count_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_receive_done |-> m_receive_count == '0)
        else $error("receive count without receive done");

    // a push result and a pop result never share one transaction
    a_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_accepted |-> !m_rx_valid && !m_receive_done)
        else $error("push and pop flags together");

    // stop leaves the bus idle and released
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_receive_done |-> !m_bus_busy && !m_sda_pull_low)
        else $error("bus still held after stop");

endmodule

bind i2c_target_bit_engine i2ctb_checker u_i2ctb_checker (.*);
